@@ rtl/core/packed_code_dot_score_top_assert.svh @@
// assertion helpers shared by the packed code dot score modules
`ifndef PACKED_CODE_DOT_SCORE_TOP_ASSERT_SVH
`define PACKED_CODE_DOT_SCORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PCDS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcds assertion failed");
`define PCDS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcds assertion failed");
`else
`define PCDS_ASSERT_IMP(name, clk, rst, ante, cons)
`define PCDS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/pcds_pkg.sv @@
package pcds_pkg;

   localparam int DIMENSIONS = 384;
   localparam int SCALE_FRAC = 14;

   localparam int ADDR_W = $clog2(DIMENSIONS) > 0 ? $clog2(DIMENSIONS) : 1;
   localparam int IDX_W = $clog2(DIMENSIONS + 1);

   // fixed field widths
   localparam int QIDX_W = 9;
   localparam int QVAL_W = 16;
   localparam int BYTE_W = 8;
   localparam int SCALE_W = 16;
   localparam int SCORE_W = 50;
   localparam int CW_W = 5;

   localparam logic [CW_W-1:0] CW_RESET = 5'd8;
   localparam logic [CW_W-1:0] CW_MIN = 5'd2;
   localparam logic [CW_W-1:0] CW_MAX = 5'd16;

   localparam int BUF_W = 24;
   localparam int HELD_W = 5;
   localparam logic [HELD_W-1:0] MAX_HELD = 5'd23;
   localparam int CODE_W = 17;

   // exact sum: each product stays within 2^30 in magnitude
   localparam int SUM_W = $clog2(DIMENSIONS) + 31;
   localparam int SPLIT = SUM_W / 2;
   localparam int MUL_A_W = (SPLIT + 1 > CODE_W) ? SPLIT + 1 : CODE_W;
   localparam int MUL_B_W = SCALE_W + 1;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int FULL_W = SUM_W + MUL_B_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   localparam logic [1:0] MUL_CODE = 2'd0;
   localparam logic [1:0] MUL_SCALE_LO = 2'd1;
   localparam logic [1:0] MUL_SCALE_HI = 2'd2;

   typedef struct packed {
      logic write_query;
      logic load_byte;
      logic issue_code;
      logic [1:0] mul_sel;
      logic save_lo;
      logic load_out;
      logic clear_record;
   } cmd_type;

   typedef struct packed {
      logic has_code;
      logic has_next;
      logic pipe_busy;
   } status_type;

endpackage

@@ rtl/core/pcds_ctrl.sv @@
`include "packed_code_dot_score_top_assert.svh"

module pcds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   input  logic                 req_last_byte,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pcds_pkg::status_type status,
   output pcds_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SCALE_LO = 3'd3;
   localparam logic [2:0] ST_SCALE_HI = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       last_ff;
   logic       last_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.mul_sel = pcds_pkg::MUL_CODE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == pcds_pkg::OP_LOAD) begin
                  cmd.write_query = 1'b1;
               end else begin
                  cmd.load_byte = 1'b1;
                  last_in = req_last_byte;
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            cmd.issue_code = status.has_code;
            if (!status.has_next) begin
               state_in = last_ff ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            // wait for the last products to land in the sum
            if (!status.pipe_busy) begin
               state_in = ST_SCALE_LO;
            end
         end
         ST_SCALE_LO: begin
            cmd.mul_sel = pcds_pkg::MUL_SCALE_LO;
            state_in = ST_SCALE_HI;
         end
         ST_SCALE_HI: begin
            cmd.mul_sel = pcds_pkg::MUL_SCALE_HI;
            cmd.save_lo = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.mul_sel = pcds_pkg::MUL_SCALE_HI;
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               cmd.clear_record = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PCDS_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || !rsp_stall)
   `PCDS_ASSERT_IMP(a_scale_drained, clock, reset, state_ff == ST_SCALE_LO, !status.pipe_busy)
   `PCDS_ASSERT_IMP(a_issue_has_code, clock, reset, cmd.issue_code, status.has_code)

endmodule

@@ rtl/core/pcds_dp.sv @@
`include "packed_code_dot_score_top_assert.svh"

module pcds_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcds_pkg::cmd_type                     cmd,
   output pcds_pkg::status_type                  status,
   input  logic                                  csr_write,
   input  logic [pcds_pkg::CW_W-1:0]             csr_code_width,
   input  logic [pcds_pkg::QIDX_W-1:0]           req_query_index,
   input  logic signed [pcds_pkg::QVAL_W-1:0]    req_query_value,
   input  logic [pcds_pkg::BYTE_W-1:0]           req_record_byte,
   input  logic [pcds_pkg::SCALE_W-1:0]          req_record_scale,
   output logic signed [pcds_pkg::SCORE_W-1:0]   rsp_score,
   output logic                                  rsp_short_record
);

   logic signed [pcds_pkg::QVAL_W-1:0] query_store [pcds_pkg::DIMENSIONS];
   logic signed [pcds_pkg::QVAL_W-1:0] query_rd_ff;

   logic [pcds_pkg::CW_W-1:0]    cw_ff;
   logic [pcds_pkg::CW_W-1:0]    cw_in;
   logic [pcds_pkg::CW_W-1:0]    width;
   logic [pcds_pkg::BUF_W-1:0]   buf_ff;
   logic [pcds_pkg::BUF_W-1:0]   buf_in;
   logic [pcds_pkg::HELD_W-1:0]  held_ff;
   logic [pcds_pkg::HELD_W-1:0]  held_in;
   logic [pcds_pkg::HELD_W-1:0]  held_rem;
   logic [pcds_pkg::IDX_W-1:0]   idx_ff;
   logic [pcds_pkg::IDX_W-1:0]   idx_in;
   logic                         idx_open;
   logic signed [pcds_pkg::SUM_W-1:0] acc_ff;
   logic signed [pcds_pkg::SUM_W-1:0] acc_in;
   logic [pcds_pkg::SCALE_W-1:0] scale_ff;

   logic [pcds_pkg::CODE_W-1:0]  mask;
   logic [pcds_pkg::CODE_W-1:0]  offset;
   logic [pcds_pkg::QVAL_W-1:0]  raw;
   logic signed [pcds_pkg::CODE_W-1:0] code;
   logic signed [pcds_pkg::CODE_W-1:0] code_ff;
   logic         a_valid_ff;
   logic         a_valid_in;
   logic         b_valid_ff;

   logic signed [pcds_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pcds_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pcds_pkg::PROD_W-1:0]  prod_in;
   logic signed [pcds_pkg::PROD_W-1:0]  prod_ff;
   logic signed [pcds_pkg::PROD_W-1:0]  lo_ff;
   logic signed [pcds_pkg::FULL_W-1:0]  full;
   logic signed [pcds_pkg::FULL_W-1:0]  shifted;
   logic signed [pcds_pkg::SCORE_W-1:0] score_ff;
   logic         short_ff;
   logic         wr_en;

   // widths outside the legal range clamp to its ends
   always_comb begin
      priority if (cw_ff < pcds_pkg::CW_MIN) begin
         width = pcds_pkg::CW_MIN;
      end else if (cw_ff > pcds_pkg::CW_MAX) begin
         width = pcds_pkg::CW_MAX;
      end else begin
         width = cw_ff;
      end
   end

   assign cw_in = csr_write ? csr_code_width : cw_ff;

   assign mask = (pcds_pkg::CODE_W'(1) << width) - pcds_pkg::CODE_W'(1);
   assign offset = pcds_pkg::CODE_W'(1) << (width - pcds_pkg::CW_W'(1));
   assign raw = buf_ff[pcds_pkg::QVAL_W-1:0] & mask[pcds_pkg::QVAL_W-1:0];
   assign code = $signed({1'b0, raw}) - $signed(offset);

   assign held_rem = held_ff - width;
   assign idx_open = (32'(idx_ff) < pcds_pkg::DIMENSIONS);

   assign status.has_code = (held_ff >= width);
   assign status.has_next = status.has_code && (held_rem >= width);
   assign status.pipe_busy = a_valid_ff || b_valid_ff;

   assign wr_en = cmd.write_query && (32'(req_query_index) < pcds_pkg::DIMENSIONS);

   always_comb begin
      buf_in = buf_ff;
      held_in = held_ff;
      idx_in = idx_ff;
      acc_in = acc_ff;
      if (cmd.load_byte) begin
         buf_in = buf_ff | (pcds_pkg::BUF_W'(req_record_byte) << held_ff);
         held_in = held_ff + pcds_pkg::HELD_W'(pcds_pkg::BYTE_W);
      end
      if (cmd.issue_code) begin
         buf_in = buf_ff >> width;
         held_in = held_rem;
         if (idx_open) begin
            idx_in = idx_ff + pcds_pkg::IDX_W'(1);
         end
      end
      if (b_valid_ff) begin
         acc_in = acc_ff + pcds_pkg::SUM_W'(prod_ff);
      end
      if (cmd.clear_record) begin
         buf_in = '0;
         held_in = '0;
         idx_in = '0;
         acc_in = '0;
      end
   end

   // codes past the last dimension are dropped here
   assign a_valid_in = cmd.issue_code && idx_open;

   // one shared multiplier: code times query, then the sum times scale in two halves
   always_comb begin
      unique case (cmd.mul_sel)
         pcds_pkg::MUL_SCALE_LO: begin
            mul_a = $signed({1'b0, acc_ff[pcds_pkg::SPLIT-1:0]});
            mul_b = $signed({1'b0, scale_ff});
         end
         pcds_pkg::MUL_SCALE_HI: begin
            mul_a = pcds_pkg::MUL_A_W'($signed(acc_ff[pcds_pkg::SUM_W-1:pcds_pkg::SPLIT]));
            mul_b = $signed({1'b0, scale_ff});
         end
         default: begin
            mul_a = pcds_pkg::MUL_A_W'(code_ff);
            mul_b = pcds_pkg::MUL_B_W'(query_rd_ff);
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign full = (pcds_pkg::FULL_W'(prod_ff) <<< pcds_pkg::SPLIT) + pcds_pkg::FULL_W'(lo_ff);
   // arithmetic shift floors; the result always fits the score range
   assign shifted = full >>> pcds_pkg::SCALE_FRAC;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         query_store[pcds_pkg::ADDR_W'(req_query_index)] <= req_query_value;
      end
      query_rd_ff <= query_store[idx_ff[pcds_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= pcds_pkg::CW_RESET;
         buf_ff <= '0;
         held_ff <= '0;
         idx_ff <= '0;
         acc_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         cw_ff <= cw_in;
         buf_ff <= buf_in;
         held_ff <= held_in;
         idx_ff <= idx_in;
         acc_ff <= acc_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code;
      prod_ff <= prod_in;
      if (cmd.load_byte) begin
         scale_ff <= req_record_scale;
      end
      if (cmd.save_lo) begin
         lo_ff <= prod_ff;
      end
      if (cmd.load_out) begin
         score_ff <= pcds_pkg::SCORE_W'(shifted);
         short_ff <= idx_open;
      end
   end

   assign rsp_score = score_ff;
   assign rsp_short_record = short_ff;

   `PCDS_ASSERT_IMP(a_held_range, clock, reset, 1'b1, held_ff <= pcds_pkg::MAX_HELD)
   `PCDS_ASSERT_IMP(a_idx_range, clock, reset, 1'b1, 32'(idx_ff) <= pcds_pkg::DIMENSIONS)
   `PCDS_ASSERT_NXT(a_clear, clock, reset, cmd.clear_record, (held_ff == '0) && (idx_ff == '0))

endmodule

@@ rtl/core/packed_code_dot_score_top.sv @@
// Scores bit-packed quantized records against a query vector held in on-chip memory.
// Request channel (req_valid / req_stall): an operation of 0 loads one signed Q3.12
// query element at req_query_index; an operation of 1 delivers the next record byte,
// codes packed LSB first at the width set through the csr_ port (2 to 16 bits).
// A record byte with req_last_byte set closes the record and uses req_record_scale.
// Response channel (rsp_valid / rsp_stall): one transaction per record with the Q37.12
// score and a flag set when the record held fewer codes than the query has elements.
// A load leaves the request channel open; a record byte stalls it while the codes
// it completes are issued. After the last byte the controller first waits for the
// multiply-accumulate pipe to drain, then runs the scale multiply in two halves on
// the same shared multiplier.
// A finished score sits in the output register; the next items are taken while it
// waits, and only the next record end holds off until the receiver takes it.
// Reset clears the record state and the response valid and sets the code width to 8;
// query memory contents are undefined until loaded.
module packed_code_dot_score_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [pcds_pkg::QIDX_W-1:0]          req_query_index,
   input  logic signed [pcds_pkg::QVAL_W-1:0]   req_query_value,
   input  logic [pcds_pkg::BYTE_W-1:0]          req_record_byte,
   input  logic [pcds_pkg::SCALE_W-1:0]         req_record_scale,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pcds_pkg::SCORE_W-1:0]  rsp_score,
   output logic                                 rsp_short_record,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcds_pkg::CW_W-1:0]            csr_code_width
);

   pcds_pkg::cmd_type    cmd;
   pcds_pkg::status_type status;

   assign csr_ready = 1'b1;

   pcds_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   pcds_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_valid && csr_ready),
      .csr_code_width   (csr_code_width),
      .req_query_index  (req_query_index),
      .req_query_value  (req_query_value),
      .req_record_byte  (req_record_byte),
      .req_record_scale (req_record_scale),
      .rsp_score        (rsp_score),
      .rsp_short_record (rsp_short_record)
   );

endmodule
